[src/assert_macros.svh]
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define SBF_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle rule");

// Consequent must hold in the same cycle as the antecedent.
`define SBF_ASSERT_SAME(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle rule");

`endif

[src/sbf_pkg.sv]
// Shared types, constants and arithmetic helpers of the stereo band filter.
package sbf_pkg;

	localparam int COMB_DEPTH = 1024;
	localparam int COMB_AW    = $clog2(COMB_DEPTH);
	localparam int LEN_W      = 10;
	localparam int REPS_W     = 4;
	localparam int MAX_REPS   = 8;
	localparam int PROD_W     = 52;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LPF_ALPHA    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HPF_ALPHA    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COMB_LENGTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT = 2'd3;

	typedef struct packed {
		logic               channel_is_left;
		logic signed [15:0] sample_in;
	} item_t;

	typedef struct packed {
		logic [31:0] stereo_word;
		logic        last;
	} result_t;

	// one finished word and how often to emit it
	typedef struct packed {
		logic [31:0]       word;
		logic [REPS_W-1:0] reps;
	} job_t;

	function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
		if (v > 38'sd2147483647) return 32'sh7fffffff;
		else if (v < -38'sd2147483648) return 32'sh80000000;
		else return $signed(v[31:0]);
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
		if (v > 40'sd32767) return 16'sh7fff;
		else if (v < -40'sd32768) return 16'sh8000;
		else return $signed(v[15:0]);
	endfunction

	// s + floor(prod / 2^15), saturated
	function automatic logic signed [31:0] pole_upd(input logic signed [31:0] s,
			input logic signed [PROD_W-1:0] prod);
		logic signed [37:0] sum;
		sum = 38'(s) + 38'(prod >>> 15);
		return sat32(sum);
	endfunction

	// prod / 2^sh truncated toward zero, saturated to 16 bits
	function automatic logic signed [15:0] trunc_sat16(input logic signed [PROD_W-1:0] prod,
			input logic [4:0] sh);
		logic signed [PROD_W-1:0] bias;
		logic signed [PROD_W-1:0] adj;
		bias = prod[PROD_W-1] ? ((PROD_W'(1) <<< sh) - PROD_W'(1)) : '0;
		adj  = prod + bias;
		return sat16(40'(adj >>> sh));
	endfunction

	function automatic logic [COMB_AW-1:0] eff_len(input logic [LEN_W-1:0] len);
		if (int'(len) >= COMB_DEPTH) return COMB_AW'(COMB_DEPTH - 1);
		else return COMB_AW'(len);
	endfunction

	function automatic logic [REPS_W-1:0] clamp_reps(input logic [REPS_W-1:0] r);
		if (r == '0) return REPS_W'(1);
		else if (int'(r) > MAX_REPS) return REPS_W'(MAX_REPS);
		else return r;
	endfunction

endpackage

[src/sbf_front.sv]
// Front end: accepts samples, runs the filter chain on a shared multiplier, applies the comb.
module sbf_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  sbf_pkg::item_t                item,
	input  logic                          cfg_we,
	input  logic [sbf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sbf_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                          job_push,
	output sbf_pkg::job_t                 job,
	input  logic                          job_full
);
	import sbf_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_LP_MUL = 4'd1;
	localparam logic [3:0] ST_LP_UPD = 4'd2;
	localparam logic [3:0] ST_T1_MUL = 4'd3;
	localparam logic [3:0] ST_T1_UPD = 4'd4;
	localparam logic [3:0] ST_H1_MUL = 4'd5;
	localparam logic [3:0] ST_H1_UPD = 4'd6;
	localparam logic [3:0] ST_H2_MUL = 4'd7;
	localparam logic [3:0] ST_H2_UPD = 4'd8;
	localparam logic [3:0] ST_T2     = 4'd9;
	localparam logic [3:0] ST_T3_MUL = 4'd10;
	localparam logic [3:0] ST_T3_UPD = 4'd11;
	localparam logic [3:0] ST_COMB   = 4'd12;
	localparam logic [3:0] ST_ADD    = 4'd13;

	logic [3:0] st_q;

	// configuration
	logic [15:0]       lpf_q;
	logic [14:0]       hpf_q;
	logic [LEN_W-1:0]  len_q;
	logic [REPS_W-1:0] reps_q;

	// per-channel filter state, index 1 = left
	logic signed [31:0] lp_q [2];
	logic signed [31:0] h1_q [2];
	logic signed [31:0] h2_q [2];

	logic               left_q;
	logic signed [15:0] x_q;
	logic signed [15:0] t_q;
	logic signed [15:0] t1_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [31:0]        packed_q;
	logic [COMB_AW-1:0] ptr_q;
	logic               use_comb_q;

	// comb line and its clearing sweep
	logic [31:0]        mem [COMB_DEPTH];
	logic [31:0]        rdata_q;
	logic [COMB_AW:0]   clr_ptr_q;
	logic [COMB_AW:0]   clr_end_q;
	logic               sweeping;

	logic signed [31:0] lp_cur, h1_cur, h2_cur;
	logic signed [33:0] mul_a;
	logic [16:0]        mul_b;
	logic [COMB_AW-1:0] len_eff, new_eff;
	logic [COMB_AW:0]   ptr_inc;
	logic [COMB_AW-1:0] ptr_nxt;
	logic [31:0]        word_l;
	logic [31:0]        word_out;
	logic signed [33:0] d2;
	logic               accept;
	logic               mem_we;
	logic [COMB_AW-1:0] mem_waddr;
	logic [31:0]        mem_wdata;

	assign sweeping = clr_ptr_q < clr_end_q;
	assign full     = (st_q != ST_IDLE) || sweeping;
	assign accept   = push && !full;

	assign lp_cur = lp_q[left_q];
	assign h1_cur = h1_q[left_q];
	assign h2_cur = h2_q[left_q];

	assign len_eff = eff_len(len_q);
	assign new_eff = eff_len(cfg_data[LEN_W-1:0]);
	assign ptr_inc = {1'b0, ptr_q} + (COMB_AW+1)'(1);
	assign ptr_nxt = (ptr_inc > {1'b0, len_eff}) ? '0 : ptr_inc[COMB_AW-1:0];
	assign word_l  = packed_q + {t_q, 16'h0000};
	assign word_out = packed_q + (use_comb_q ? rdata_q : 32'h0);
	assign d2 = 34'({{10{t1_q[15]}}, t1_q, 8'h00}) - 34'(h2_cur);

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			ST_LP_MUL: begin
				mul_a = 34'({{10{x_q[15]}}, x_q, 8'h00}) - 34'(lp_cur);
				mul_b = {1'b0, lpf_q};
			end
			ST_T1_MUL: begin
				mul_a = 34'(lp_cur);
				mul_b = 17'h10000 - {1'b0, lpf_q};
			end
			ST_H1_MUL: begin
				mul_a = 34'({{10{t1_q[15]}}, t1_q, 8'h00}) - 34'(h1_cur);
				mul_b = {2'b00, hpf_q};
			end
			ST_H2_MUL: begin
				mul_a = 34'(h1_cur) - 34'(h2_cur);
				mul_b = {2'b00, hpf_q};
			end
			ST_T3_MUL: begin
				mul_a = 34'(t_q);
				mul_b = 17'h08000 + {1'b0, hpf_q, 1'b0} + {2'b00, hpf_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// sequencer, configuration registers, clearing sweep, filter state and comb pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			lpf_q      <= 16'd32768;
			hpf_q      <= 15'd655;
			len_q      <= '0;
			reps_q     <= REPS_W'(2);
			lp_q[0]    <= '0;
			lp_q[1]    <= '0;
			h1_q[0]    <= '0;
			h1_q[1]    <= '0;
			h2_q[0]    <= '0;
			h2_q[1]    <= '0;
			packed_q   <= '0;
			ptr_q      <= '0;
			clr_ptr_q  <= '0;
			clr_end_q  <= (COMB_AW+1)'(COMB_DEPTH);
		end else begin
			if (sweeping) clr_ptr_q <= clr_ptr_q + (COMB_AW+1)'(1);
			// register writes; raising the length schedules a clear
			if (cfg_we) begin
				case (cfg_index)
					CFG_LPF_ALPHA:    lpf_q  <= cfg_data;
					CFG_HPF_ALPHA:    hpf_q  <= cfg_data[14:0];
					CFG_COMB_LENGTH: begin
						len_q <= cfg_data[LEN_W-1:0];
						if (new_eff > len_eff) begin
							if (sweeping) begin
								if ({1'b0, new_eff} > clr_end_q) clr_end_q <= {1'b0, new_eff};
							end else begin
								clr_ptr_q <= {1'b0, len_eff};
								clr_end_q <= {1'b0, new_eff};
							end
						end
					end
					CFG_REPEAT_COUNT: reps_q <= cfg_data[REPS_W-1:0];
					default: ;
				endcase
			end
			case (st_q)
				ST_IDLE:   if (accept) st_q <= ST_LP_MUL;
				ST_LP_MUL: st_q <= ST_LP_UPD;
				ST_LP_UPD: begin
					lp_q[left_q] <= pole_upd(lp_cur, prod_q);
					st_q <= ST_T1_MUL;
				end
				ST_T1_MUL: st_q <= ST_T1_UPD;
				ST_T1_UPD: st_q <= ST_H1_MUL;
				ST_H1_MUL: st_q <= ST_H1_UPD;
				ST_H1_UPD: begin
					h1_q[left_q] <= pole_upd(h1_cur, prod_q);
					st_q <= ST_H2_MUL;
				end
				ST_H2_MUL: st_q <= ST_H2_UPD;
				ST_H2_UPD: begin
					h2_q[left_q] <= pole_upd(h2_cur, prod_q);
					st_q <= ST_T2;
				end
				ST_T2:     st_q <= ST_T3_MUL;
				ST_T3_MUL: st_q <= ST_T3_UPD;
				ST_T3_UPD: st_q <= ST_COMB;
				ST_COMB: begin
					if (left_q) begin
						packed_q <= word_l;
						ptr_q    <= ptr_nxt;
						st_q     <= ST_ADD;
					end else begin
						packed_q <= {{16{t_q[15]}}, t_q};
						st_q     <= ST_IDLE;
					end
				end
				ST_ADD: begin
					if (!job_full) begin
						packed_q <= word_out;
						st_q     <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (accept) begin
			left_q <= item.channel_is_left;
			x_q    <= item.sample_in;
		end
		prod_q <= mul_a * $signed({1'b0, mul_b});
		if (st_q == ST_T1_UPD) begin
			t1_q <= trunc_sat16(prod_q, 5'd23);
		end
		if (st_q == ST_T2) begin
			t_q <= sat16(40'((d2 + (d2[33] ? 34'sd255 : 34'sd0)) >>> 8));
		end
		if (st_q == ST_T3_UPD) begin
			t_q <= trunc_sat16(prod_q, 5'd15);
		end
		if (st_q == ST_COMB) begin
			use_comb_q <= (len_eff != '0);
		end
	end

	// comb line write port: clearing sweep or new word
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = word_l;
		if (sweeping) begin
			mem_we    = 1'b1;
			mem_waddr = clr_ptr_q[COMB_AW-1:0];
			mem_wdata = '0;
		end else if (st_q == ST_COMB && left_q) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (st_q == ST_COMB && left_q) rdata_q <= mem[ptr_nxt];
	end

	assign job_push = (st_q == ST_ADD) && !job_full;
	assign job.word = word_out;
	assign job.reps = clamp_reps(reps_q);

endmodule

[src/sbf_queue.sv]
// Two-entry queue of finished words between front and back end.
module sbf_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  sbf_pkg::job_t wdata,
	output logic          q_full,
	input  logic          rd,
	output sbf_pkg::job_t rdata,
	output logic          q_empty
);
	import sbf_pkg::*;

	job_t       slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign q_full  = cnt_q == 2'd2;
	assign q_empty = cnt_q == 2'd0;
	assign rdata   = slot_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) slot_q[wp_q] <= wdata;
	end

endmodule

[src/sbf_emit.sv]
// Back end: emits each queued word its repeat count of times through an output register.
module sbf_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  sbf_pkg::job_t    q_data,
	output logic             q_pop,
	output logic             empty,
	input  logic             pop,
	output sbf_pkg::result_t result
);
	import sbf_pkg::*;

	logic              vld_q;
	logic [31:0]       word_q;
	logic [REPS_W-1:0] cnt_q;
	logic              is_last, adv;

	assign is_last = cnt_q == REPS_W'(1);
	assign adv     = vld_q && pop;
	assign q_pop   = !q_empty && (!vld_q || (adv && is_last));

	// remaining-repeat counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			cnt_q <= '0;
		end else if (q_pop) begin
			vld_q <= 1'b1;
			cnt_q <= q_data.reps;
		end else if (adv) begin
			if (is_last) vld_q <= 1'b0;
			else cnt_q <= cnt_q - REPS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) word_q <= q_data.word;
	end

	assign empty              = !vld_q;
	assign result.stereo_word = word_q;
	assign result.last        = is_last;

endmodule

[src/stereo_band_filter_comb.sv]
// Top level of the stereo band filter with feedforward comb.
// Input channel: push/full queue of samples tagged left or right; a request is
// taken when push is high and full is low. Output channel: empty/pop queue of
// packed stereo words; a request leaves when pop is high and empty is low.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle.
// In the filter sequencer a sample runs through five multiplies on the single
// shared multiplier, each with its own update state, the highpass difference
// step, the comb step (comb write and read for a left sample) and, for a left
// sample, the add step. One sample is in the filter at a time; full stays
// high until it is done.
// A left sample yields repeat_count results, clamped to one through eight,
// one per cycle while pop is high, through the queue and the output register.
// A two-entry queue sits between filter and emitter, so the filter keeps
// working while the receiver stalls, until that queue fills.
// After reset, full stays high while the whole comb line is cleared.
// Raising comb_length clears the entries from the old length up to one below
// the new length at one per cycle, with full held high during that sweep.
module stereo_band_filter_comb (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  sbf_pkg::item_t                 item,
	output logic                           empty,
	input  logic                           pop,
	output sbf_pkg::result_t               result,
	input  logic                           cfg_we,
	input  logic [sbf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sbf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sbf_pkg::*;

	logic job_push, job_full, q_empty, q_pop;
	job_t job, q_data;

	sbf_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.job_push(job_push), .job(job), .job_full(job_full)
	);

	sbf_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(job_push), .wdata(job), .q_full(job_full),
		.rd(q_pop), .rdata(q_data), .q_empty(q_empty)
	);

	sbf_emit u_emit (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_data(q_data), .q_pop(q_pop),
		.empty(empty), .pop(pop), .result(result)
	);

endmodule

[src/sbf_checker.sv]
// Port-level checker for the stereo band filter, bound to the top level.
`include "assert_macros.svh"

module sbf_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             push,
	input logic             full,
	input logic             empty,
	input logic             pop,
	input sbf_pkg::result_t result
);
	import sbf_pkg::*;

	// a stalled result stays put
	`SBF_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(result))
	// a repeated word continues until its last copy
	`SBF_ASSERT_NEXT(a_repeat, clk, arst_n, !empty && pop && !result.last, !empty)
	// an accepted request occupies the filter
	`SBF_ASSERT_NEXT(a_busy, clk, arst_n, push && !full, full)

endmodule

bind stereo_band_filter_comb sbf_checker u_sbf_checker (.*);

[tb/sv/tb_stereo_band_filter_comb.sv]
// Self-checking testbench of the stereo band filter with feedforward comb.
module tb_stereo_band_filter_comb;
	timeunit 1ns;
	timeprecision 1ps;
	import sbf_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	item_t item = '0;
	logic empty;
	logic pop = 1'b0;
	result_t result;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	stereo_band_filter_comb i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// predictor state
	logic [15:0] pm_lpf_alpha;
	logic [14:0] pm_hpf_alpha;
	logic [9:0] pm_comb_len;
	logic [3:0] pm_reps;
	logic signed [31:0] lp_l, lp_r, h1_l, h1_r, h2_l, h2_r;
	logic [31:0] pword;
	logic [31:0] comb_mem [COMB_DEPTH];
	int unsigned comb_ptr;

	item_t pending_items[$];
	result_t expected_words[$];
	int mismatch_count = 0;
	int cycle_count = 0;
	bit quiet_mode = 1'b0;
	bit hold_push = 1'b0;

	function automatic longint floor15(longint v);
		if (v >= 0) return v / 32768;
		return -(((-v) - 1) / 32768) - 1;
	endfunction

	function automatic logic signed [31:0] clip32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic longint clip16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic int unsigned length_in_use(logic [9:0] len);
		return (int'(len) >= COMB_DEPTH) ? COMB_DEPTH - 1 : int'(len);
	endfunction

	task automatic pole_step(inout logic signed [31:0] s, input longint target,
			input longint alpha);
		longint d;
		d = target - longint'(s);
		s = clip32(longint'(s) + floor15(alpha * d));
	endtask

	// three filter stages of one channel
	task automatic band_filter(input longint x, inout logic signed [31:0] lp,
			inout logic signed [31:0] h1, inout logic signed [31:0] h2,
			output longint y);
		longint t1, t2, p;
		pole_step(lp, x * 256, longint'(pm_lpf_alpha));
		p = longint'(lp) * (65536 - longint'(pm_lpf_alpha));
		t1 = clip16(p / 8388608);
		pole_step(h1, t1 * 256, longint'(pm_hpf_alpha));
		pole_step(h2, longint'(h1), longint'(pm_hpf_alpha));
		t2 = clip16((t1 * 256 - longint'(h2)) / 256);
		p = t2 * (32768 + 3 * longint'(pm_hpf_alpha));
		y = clip16(p / 32768);
	endtask

	task automatic predict_words(input item_t it);
		longint y;
		int unsigned len, n;
		result_t r;
		if (!it.channel_is_left) begin
			band_filter(longint'(it.sample_in), lp_r, h1_r, h2_r, y);
			pword = 32'(y);
			return;
		end
		band_filter(longint'(it.sample_in), lp_l, h1_l, h2_l, y);
		pword = pword + {y[15:0], 16'h0};
		len = length_in_use(pm_comb_len);
		comb_mem[comb_ptr] = pword;
		comb_ptr++;
		if (comb_ptr > len) comb_ptr = 0;
		if (len != 0) pword = pword + comb_mem[comb_ptr];
		n = (pm_reps == 0) ? 1 : (pm_reps > 8 ? 8 : pm_reps);
		for (int k = 0; k < n; k++) begin
			r.stereo_word = pword;
			r.last = (k + 1 == n);
			expected_words.push_back(r);
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatch_count++;
	endtask

	// register write driven after the next edge, mirrored into the predictor
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		int unsigned old_len, new_len;
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_LPF_ALPHA: pm_lpf_alpha = val;
			CFG_HPF_ALPHA: pm_hpf_alpha = val[14:0];
			CFG_COMB_LENGTH: begin
				old_len = length_in_use(pm_comb_len);
				pm_comb_len = val[9:0];
				new_len = length_in_use(pm_comb_len);
				for (int i = old_len; i < new_len; i++) comb_mem[i] = '0;
			end
			CFG_REPEAT_COUNT: pm_reps = val[3:0];
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || expected_words.size() != 0 || push)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic item_t rand_item(bit left);
		item_t it;
		it.channel_is_left = left;
		case ($urandom_range(0, 5))
			0: it.sample_in = 16'sh7fff;
			1: it.sample_in = 16'sh8000;
			default: it.sample_in = 16'($urandom);
		endcase
		return it;
	endfunction

	task automatic random_phase(input int pairs);
		for (int i = 0; i < pairs; i++) begin
			if ($urandom_range(0, 9) == 0)
				pending_items.push_back(rand_item(1'($urandom_range(0, 1))));
			else begin
				pending_items.push_back(rand_item(1'b0));
				pending_items.push_back(rand_item(1'b1));
			end
		end
		wait_drained();
	endtask

	// driver: takes pending items, idles at random unless in quiet mode
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				predict_words(item);
			end
			if (!(push && full)) begin
				if (pending_items.size() != 0 && !hold_push &&
						(quiet_mode || $urandom_range(0, 99) >= 18)) begin
					push <= 1'b1;
					item <= pending_items.pop_front();
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor: pops results at random (always in quiet mode) and checks them
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_words.size() == 0)
					report_mismatch("result with no expectation");
				else begin
					result_t e;
					e = expected_words.pop_front();
					if (result.stereo_word !== e.stereo_word)
						report_mismatch($sformatf("stereo_word %h, expected %h",
							result.stereo_word, e.stereo_word));
					if (result.last !== e.last)
						report_mismatch($sformatf("last %b, expected %b",
							result.last, e.last));
				end
			end
			pop <= quiet_mode || ($urandom_range(0, 99) >= 18);
		end
	end

	// run length guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		item_t it;
		pm_lpf_alpha = 16'd32768;
		pm_hpf_alpha = 15'd655;
		pm_comb_len = '0;
		pm_reps = 4'd2;
		lp_l = 0; lp_r = 0; h1_l = 0; h1_r = 0; h2_l = 0; h2_r = 0;
		pword = '0;
		comb_ptr = 0;
		foreach (comb_mem[i]) comb_mem[i] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, right only, two lefts in a row
		it.channel_is_left = 1'b0; it.sample_in = 16'sh7fff; pending_items.push_back(it);
		it.channel_is_left = 1'b1; it.sample_in = 16'sh8000; pending_items.push_back(it);
		it.channel_is_left = 1'b1; it.sample_in = 16'sh7fff; pending_items.push_back(it);
		it.channel_is_left = 1'b0; it.sample_in = 16'sh8000; pending_items.push_back(it);
		it.channel_is_left = 1'b0; it.sample_in = 16'sh0000; pending_items.push_back(it);
		it.channel_is_left = 1'b1; it.sample_in = 16'shffff; pending_items.push_back(it);
		wait_drained();

		// short comb, max reps, extreme alphas
		write_reg(CFG_LPF_ALPHA, 16'd1638);
		write_reg(CFG_HPF_ALPHA, 16'd21299);
		write_reg(CFG_COMB_LENGTH, 16'd3);
		write_reg(CFG_REPEAT_COUNT, 16'd8);
		for (int i = 0; i < 8; i++) pending_items.push_back(rand_item(1'b1));
		for (int i = 0; i < 4; i++) pending_items.push_back(rand_item(i[0]));
		wait_drained();

		// out of range values: reps zero and above eight, wide alphas
		write_reg(CFG_REPEAT_COUNT, 16'd0);
		write_reg(CFG_LPF_ALPHA, 16'hffff);
		write_reg(CFG_HPF_ALPHA, 16'h7fff);
		random_phase(4);
		write_reg(CFG_REPEAT_COUNT, 16'hf);
		write_reg(CFG_LPF_ALPHA, 16'd0);
		write_reg(CFG_HPF_ALPHA, 16'd0);
		random_phase(3);

		// lower the length below the pointer, then raise it past old entries
		write_reg(CFG_COMB_LENGTH, 16'd1);
		write_reg(CFG_REPEAT_COUNT, 16'd1);
		random_phase(3);
		write_reg(CFG_COMB_LENGTH, 16'd7);
		random_phase(6);

		// long random phases over several settings
		write_reg(CFG_LPF_ALPHA, 16'd32768);
		write_reg(CFG_HPF_ALPHA, 16'd655);
		write_reg(CFG_COMB_LENGTH, 16'd1000);
		write_reg(CFG_REPEAT_COUNT, 16'd2);
		random_phase(50);
		// sender held back for a while with a request waiting
		hold_push = 1'b1;
		pending_items.push_back(rand_item(1'b1));
		repeat (60) @(posedge clk);
		hold_push = 1'b0;
		wait_drained();
		write_reg(CFG_COMB_LENGTH, 16'd1023);
		write_reg(CFG_LPF_ALPHA, 16'($urandom_range(1638, 32768)));
		write_reg(CFG_HPF_ALPHA, 16'($urandom_range(655, 21299)));
		quiet_mode = 1'b1;
		random_phase(40);
		quiet_mode = 1'b0;
		write_reg(CFG_COMB_LENGTH, 16'd0);
		write_reg(CFG_REPEAT_COUNT, 16'($urandom_range(1, 8)));
		random_phase(40);
		write_reg(CFG_COMB_LENGTH, 16'($urandom_range(1, 20)));
		write_reg(CFG_LPF_ALPHA, 16'($urandom_range(1638, 32768)));
		random_phase(40);

		wait_drained();
		if (mismatch_count == 0 && expected_words.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
